FILE: hw/rtl/anp_pkg.sv
// Shared types and constants of the ASCII number parser.
// Status codes, character codes, register indexes and control/status structs.
// No dependencies.
`default_nettype none

package anp_pkg;

  localparam int CHAR_W   = 8;
  localparam int BASE_W   = 6;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 3;
  localparam int FRAC_W   = 30;
  localparam int PROD_W   = VALUE_W + BASE_W;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTNUM = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BASE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVF    = 3'd4;

  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

  localparam logic CFG_NUMBER_BASE  = 1'b0;
  localparam logic CFG_DECIMAL_MODE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  typedef struct packed {
    logic load;
    logic update;
    logic finish;
    logic div_start;
    logic add_frac;
    logic check_mag;
    logic emit;
  } anp_cmd_t;

  typedef struct packed {
    logic last;
    logic need_div;
    logic div_done;
  } anp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/anp_divider.sv
// Restoring divider, one quotient bit per cycle.
// Used for the rounded fraction of the parser; no package dependency.
`default_nettype none

module anp_divider #(
  parameter int DIVIDEND_W = 63,
  parameter int DIVISOR_W  = 30
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire  [DIVIDEND_W-1:0] dividend,
  input  wire  [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] q_r, q_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  ge;

  assign shifted = {rem_r, q_r[DIVIDEND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};
  assign ge      = ~diff[DIVISOR_W+1];

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIVIDEND_W-2:0], ge};
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

FILE: hw/rtl/anp_datapath.sv
// Parser datapath: configuration, parse state, digit multiply-add, final value.
// Depends on anp_pkg and anp_divider.
`default_nettype none

module anp_datapath
  import anp_pkg::*;
#(
  parameter int FRAC_BITS       = 32,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr,
  input  wire                 cfg_index,
  input  wire  [BASE_W-1:0]   cfg_data,
  input  wire  [CHAR_W-1:0]   in_char,
  input  wire                 in_last,
  input  anp_cmd_t            cmd,
  output anp_sts_t            sts,
  output logic [VALUE_W-1:0]  out_value,
  output logic [STATUS_W-1:0] out_status
);

  localparam int CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int DIVD_W = FRAC_W + FRAC_BITS + 1;

  logic [BASE_W-1:0]   nb_r, nb_nxt;
  logic                dm_r, dm_nxt;
  logic [VALUE_W-1:0]  acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic                first_r, first_nxt;
  logic                point_r, point_nxt;
  logic                hasint_r, hasint_nxt;
  logic [FRAC_W-1:0]   fnum_r, fnum_nxt;
  logic [FRAC_W-1:0]   fscale_r, fscale_nxt;
  logic [CNT_W-1:0]    fcnt_r, fcnt_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                last_r, last_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic [VALUE_W-1:0]  oval_r, oval_nxt;
  logic [STATUS_W-1:0] ostat_r, ostat_nxt;

  logic                fixed;
  logic [BASE_W-1:0]   base_clamp;
  logic [BASE_W-1:0]   base;
  logic                dig_ok;
  logic [BASE_W-1:0]   dig;
  logic [VALUE_W-1:0]  lim_full;
  logic [VALUE_W-1:0]  lim_int;
  logic [PROD_W-1:0]   sum;
  logic                ovf;
  logic                err_ok;
  logic [FRAC_W-1:0]   scale_eff;
  logic [DIVD_W-1:0]   dividend;
  logic [DIVD_W-1:0]   quotient;
  logic                div_done;

  assign fixed  = dm_r | point_r;
  assign err_ok = (err_r == ST_OK);

  always_comb begin
    if (nb_r < BASE_MIN) base_clamp = BASE_MIN;
    else if (nb_r > BASE_MAX) base_clamp = BASE_MAX;
    else base_clamp = nb_r;
  end

  assign base = fixed ? BASE_DEC : base_clamp;

  always_comb begin
    dig_ok = 1'b1;
    dig    = '0;
    if (char_r >= CH_ZERO && char_r <= CH_NINE) begin
      dig = BASE_W'(char_r - CH_ZERO);
    end else if (char_r >= CH_LOWER_A && char_r <= CH_LOWER_Z) begin
      dig = BASE_W'(char_r - CH_LOWER_A + 8'd10);
    end else if (char_r >= CH_UPPER_A && char_r <= CH_UPPER_Z) begin
      dig = BASE_W'(char_r - CH_UPPER_A + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign lim_full = neg_r ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
  assign lim_int  = fixed ? (lim_full >> FRAC_BITS) : lim_full;
  assign sum      = prod_r + PROD_W'(dig);
  assign ovf      = sum > PROD_W'(lim_int);

  assign scale_eff = (fscale_r == '0) ? FRAC_W'(1) : fscale_r;
  assign dividend  = (DIVD_W'(fnum_r) << FRAC_BITS) + DIVD_W'(scale_eff >> 1);

  anp_divider #(
    .DIVIDEND_W (DIVD_W),
    .DIVISOR_W  (FRAC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (scale_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    nb_nxt     = nb_r;
    dm_nxt     = dm_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    first_nxt  = first_r;
    point_nxt  = point_r;
    hasint_nxt = hasint_r;
    fnum_nxt   = fnum_r;
    fscale_nxt = fscale_r;
    fcnt_nxt   = fcnt_r;
    err_nxt    = err_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    prod_nxt   = prod_r;
    mag_nxt    = mag_r;
    oval_nxt   = oval_r;
    ostat_nxt  = ostat_r;

    if (cfg_wr) begin
      case (cfg_index)
        CFG_NUMBER_BASE:  nb_nxt = cfg_data;
        CFG_DECIMAL_MODE: dm_nxt = cfg_data[0];
        default: ;
      endcase
    end

    if (cmd.load) begin
      char_nxt = in_char;
      last_nxt = in_last;
      prod_nxt = PROD_W'(acc_r) * PROD_W'(base);
    end

    if (cmd.update) begin
      first_nxt = 1'b0;
      if (err_ok) begin
        if (first_r && char_r == CH_MINUS) begin
          neg_nxt = 1'b1;
        end else if (dm_r && char_r == CH_POINT && !point_r) begin
          if (!hasint_r) err_nxt = ST_EMPTY;
          else point_nxt = 1'b1;
        end else if (!dig_ok) begin
          err_nxt = ST_NOTNUM;
        end else if (dig >= base) begin
          err_nxt = ST_BASE;
        end else if (point_r) begin
          if (fcnt_r < CNT_W'(MAX_FRAC_DIGITS)) begin
            fnum_nxt   = fnum_r * FRAC_W'(10) + FRAC_W'(dig);
            fscale_nxt = fscale_r * FRAC_W'(10);
            fcnt_nxt   = fcnt_r + CNT_W'(1);
          end
        end else if (ovf) begin
          err_nxt = ST_OVF;
        end else begin
          acc_nxt    = sum[VALUE_W-1:0];
          hasint_nxt = 1'b1;
        end
      end
    end

    if (cmd.finish) begin
      mag_nxt = acc_r;
      if (err_ok && !hasint_r) err_nxt = ST_EMPTY;
      else if (err_ok && fixed && acc_r > lim_int) err_nxt = ST_OVF;
    end

    if (cmd.add_frac) begin
      mag_nxt = (acc_r << FRAC_BITS) + VALUE_W'(quotient[FRAC_BITS:0]);
    end

    if (cmd.check_mag) begin
      if (mag_r > lim_full) err_nxt = ST_OVF;
    end

    if (cmd.emit) begin
      oval_nxt   = err_ok ? (neg_r ? (~mag_r + VALUE_W'(1)) : mag_r) : '0;
      ostat_nxt  = err_r;
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      first_nxt  = 1'b1;
      point_nxt  = 1'b0;
      hasint_nxt = 1'b0;
      fnum_nxt   = '0;
      fscale_nxt = FRAC_W'(1);
      fcnt_nxt   = '0;
      err_nxt    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    prod_r  <= prod_nxt;
    mag_r   <= mag_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
    if (!rst_n) begin
      nb_r     <= BASE_RESET;
      dm_r     <= 1'b0;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      first_r  <= 1'b1;
      point_r  <= 1'b0;
      hasint_r <= 1'b0;
      fnum_r   <= '0;
      fscale_r <= FRAC_W'(1);
      fcnt_r   <= '0;
      err_r    <= ST_OK;
    end else begin
      nb_r     <= nb_nxt;
      dm_r     <= dm_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      first_r  <= first_nxt;
      point_r  <= point_nxt;
      hasint_r <= hasint_nxt;
      fnum_r   <= fnum_nxt;
      fscale_r <= fscale_nxt;
      fcnt_r   <= fcnt_nxt;
      err_r    <= err_nxt;
    end
  end

  assign sts.last     = last_r;
  assign sts.need_div = err_ok && hasint_r && fixed && !(acc_r > lim_int);
  assign sts.div_done = div_done;
  assign out_value    = oval_r;
  assign out_status   = ostat_r;

endmodule

`default_nettype wire

FILE: hw/rtl/anp_ctrl.sv
// Parser controller: sequences load, update, finish, divide and output transfer.
// Depends on anp_pkg.
`default_nettype none

module anp_ctrl
  import anp_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire       out_tready,
  input  anp_sts_t  sts,
  output anp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = sts.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add_frac = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        cmd.check_mag = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.emit) ovalid_nxt = 1'b1;
    else if (out_tready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_UPD)
    else $error("accepted byte not followed by update");

  a_inner_byte_returns: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD && !sts.last |=> state_r == S_IDLE)
    else $error("non-final byte did not return to idle");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && !sts.div_done |=> state_r == S_DIV)
    else $error("left division before it finished");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("result loaded without valid");

endmodule

`default_nettype wire

FILE: hw/rtl/ascii_number_parser_top.sv
// ASCII number parser top level: stream ports, configuration port, wiring.
// Depends on anp_pkg, anp_ctrl, anp_datapath (with anp_divider).
//
// Bytes of a number text arrive one per transfer on the in_ stream, in_tlast
// marking the final byte; each text yields one result on the out_ stream:
// out_tdata is the signed value (integer, or fixed point with FRAC_BITS
// fraction bits in decimal mode or once a point is seen) and out_tuser the
// status (ok, empty integer part, not numeric, digit beyond base, overflow;
// value is zero on error). Each byte is accepted and the accumulator times
// base product formed, then the digit is added and the limit checked. The
// final byte passes the finish and output states in integer form, and in
// fixed-point form also divide, fraction-add and check states; the restoring
// divider gives one fraction quotient bit per cycle. A finished result waits
// in the output register; a following non-final byte is taken meanwhile.
`default_nettype none

module ascii_number_parser_top
  import anp_pkg::*;
#(
  parameter int FRAC_BITS       = 32,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [7:0]          in_tdata,   // [7:0] character
  input  wire                 in_tlast,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [63:0]         out_tdata,  // [63:0] value
  output logic [7:0]          out_tuser,  // [2:0] status
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire                 cfg_index,
  input  wire  [BASE_W-1:0]   cfg_data
);

  anp_cmd_t            cmd;
  anp_sts_t            sts;
  logic [STATUS_W-1:0] status;

  assign cfg_ready = 1'b1;

  anp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  anp_datapath #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_value  (out_tdata),
    .out_status (status)
  );

  assign out_tuser = {5'b0, status};

endmodule

`default_nettype wire
